@@ src/jhmp_pkg.sv @@
// ----------------------------------------------------------------------------
// JPEG header marker parser package
// Marker codes, status codes, table sizes and the per-byte result type.
// ----------------------------------------------------------------------------
package jhmp_pkg;

    localparam int HUFF_COPY_BYTES = 418;
    localparam int QTABLE_BYTES    = 64;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_DRI    = 8'hDD;
    localparam logic [7:0] MK_DQT    = 8'hDB;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_APP0   = 8'hE0;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_APP15  = 8'hEF;

    localparam logic [1:0] ST_IN_HEADER  = 2'd0;
    localparam logic [1:0] ST_HEADER_END = 2'd1;
    localparam logic [1:0] ST_ERROR      = 2'd2;
    localparam logic [1:0] ST_PAST       = 2'd3;

    typedef struct packed {
        logic [15:0] restart_interval;
        logic [7:0]  height_blocks;
        logic [7:0]  width_blocks;
        logic [7:0]  table_byte;
        logic [8:0]  table_index;
        logic        huff_write;
        logic        qtable_mirror;
        logic        qtable_write;
        logic [7:0]  marker_code;
        logic [15:0] header_length;
        logic [1:0]  status;
    } t_jhmp_result;

endpackage

@@ src/jhmp_core.sv @@
// ----------------------------------------------------------------------------
// JPEG header marker parser core
// Holds the segment walk state and forms the result for one frame byte.
// ----------------------------------------------------------------------------
module jhmp_core
    import jhmp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_data_byte,
    input  logic         i_frame_start,
    output t_jhmp_result o_result
);

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_CODE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_DONE
    } t_phase;

    t_phase      r_phase,    n_phase,    c_phase;
    logic [15:0] r_pos,      n_pos,      c_pos;
    logic [7:0]  r_code,     n_code,     c_code;
    logic [15:0] r_len,      n_len,      c_len;
    logic [15:0] r_off,      n_off,      c_off;
    logic [7:0]  r_held,     n_held,     c_held;
    logic [7:0]  r_width,    n_width;
    logic [7:0]  r_height,   n_height;
    logic [15:0] r_restart,  n_restart;

    logic [15:0] pos_inc;
    logic [16:0] off_inc;
    logic [15:0] word_val;
    logic [15:0] sof_val;
    logic        long_dqt;

    always_comb begin
        if (i_frame_start) begin
            c_phase = PH_PREFIX;
            c_pos   = '0;
            c_code  = '0;
            c_len   = '0;
            c_off   = '0;
            c_held  = '0;
        end else begin
            c_phase = r_phase;
            c_pos   = r_pos;
            c_code  = r_code;
            c_len   = r_len;
            c_off   = r_off;
            c_held  = r_held;
        end

        pos_inc  = (c_pos == 16'hFFFF) ? c_pos : c_pos + 16'd1;
        off_inc  = {1'b0, c_off} + 17'd1;
        word_val = {c_held, i_data_byte};
        sof_val  = word_val >> 3;
        long_dqt = c_len >= 16'(2 * QTABLE_BYTES);

        n_phase   = c_phase;
        n_pos     = c_pos;
        n_code    = c_code;
        n_len     = c_len;
        n_off     = c_off;
        n_held    = c_held;
        n_width   = r_width;
        n_height  = r_height;
        n_restart = r_restart;

        o_result = '0;

        unique case (c_phase)
            PH_PREFIX: begin
                if (i_data_byte == MK_PREFIX) begin
                    n_pos   = pos_inc;
                    n_phase = PH_CODE;
                end else begin
                    o_result.status        = ST_HEADER_END;
                    o_result.header_length = c_pos;
                    n_phase                = PH_DONE;
                end
            end
            PH_CODE: begin
                n_pos  = pos_inc;
                n_code = i_data_byte;
                if (i_data_byte == MK_SOI) begin
                    n_phase = PH_PREFIX;
                end else if (i_data_byte == MK_DRI || i_data_byte == MK_DQT ||
                             i_data_byte == MK_DHT || i_data_byte == MK_SOF0 ||
                             i_data_byte == MK_APP0 || i_data_byte == MK_SOS ||
                             i_data_byte == MK_APP15) begin
                    n_phase = PH_LEN_HI;
                end else begin
                    o_result.status = ST_ERROR;
                    n_phase         = PH_DONE;
                end
            end
            PH_LEN_HI: begin
                n_pos  = pos_inc;
                n_held = i_data_byte;
                if (c_code == MK_DHT) begin
                    o_result.huff_write = 1'b1;
                    o_result.table_byte = i_data_byte;
                end
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_pos = pos_inc;
                n_len = word_val;
                if (word_val < 16'd2) begin
                    o_result.status = ST_ERROR;
                    n_phase         = PH_DONE;
                end else begin
                    if (c_code == MK_DHT && HUFF_COPY_BYTES > 1) begin
                        o_result.huff_write  = 1'b1;
                        o_result.table_index = 9'd1;
                        o_result.table_byte  = i_data_byte;
                    end
                    n_off   = 16'd2;
                    n_phase = (word_val == 16'd2) ? PH_PREFIX : PH_BODY;
                end
            end
            PH_BODY: begin
                n_pos = pos_inc;
                if (c_code == MK_DQT) begin
                    if (c_off >= 16'd3 && c_off < 16'(QTABLE_BYTES + 3)) begin
                        o_result.qtable_write  = 1'b1;
                        o_result.qtable_mirror = !long_dqt;
                        o_result.table_index   = 9'(c_off - 16'd3);
                        o_result.table_byte    = i_data_byte;
                    end else if (long_dqt && c_off >= 16'(QTABLE_BYTES + 4) &&
                                 c_off < 16'(2 * QTABLE_BYTES + 4)) begin
                        o_result.qtable_write = 1'b1;
                        o_result.table_index  = 9'(c_off - 16'd4);
                        o_result.table_byte   = i_data_byte;
                    end
                end else if (c_code == MK_DHT) begin
                    if (c_off < 16'(HUFF_COPY_BYTES)) begin
                        o_result.huff_write  = 1'b1;
                        o_result.table_index = c_off[8:0];
                        o_result.table_byte  = i_data_byte;
                    end
                end else if (c_code == MK_SOF0) begin
                    if (c_off == 16'd3 || c_off == 16'd5) begin
                        n_held = i_data_byte;
                    end else if (c_off == 16'd4) begin
                        n_height = sof_val[7:0];
                    end else if (c_off == 16'd6) begin
                        n_width = sof_val[7:0];
                    end
                end else if (c_code == MK_DRI) begin
                    if (c_off == 16'd2) begin
                        n_held = i_data_byte;
                    end else if (c_off == 16'd3) begin
                        n_restart = word_val;
                    end
                end
                n_off = off_inc[15:0];
                if (off_inc >= {1'b0, c_len}) begin
                    n_phase = PH_PREFIX;
                end
            end
            default: begin
                o_result.status = ST_PAST;
                n_phase         = PH_DONE;
            end
        endcase

        o_result.marker_code      = n_code;
        o_result.width_blocks     = n_width;
        o_result.height_blocks    = n_height;
        o_result.restart_interval = n_restart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PREFIX;
            r_pos     <= '0;
            r_code    <= '0;
            r_len     <= '0;
            r_off     <= '0;
            r_held    <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_restart <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_code    <= n_code;
            r_len     <= n_len;
            r_off     <= n_off;
            r_held    <= n_held;
            r_width   <= n_width;
            r_height  <= n_height;
            r_restart <= n_restart;
        end
    end

    a_one_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result.qtable_write && o_result.huff_write))
        else $error("quant and huffman writes at once");

    a_mirror_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.qtable_mirror |-> (o_result.qtable_write && o_result.table_index < 9'd64))
        else $error("mirror outside low quant half");

    a_qidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.qtable_write |-> o_result.table_index < 9'(2 * QTABLE_BYTES))
        else $error("quant index out of range");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && i_accept && !i_frame_start) |=> r_phase == PH_DONE)
        else $error("left done phase without frame start");

    a_body_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_off < r_len)
        else $error("segment offset past length");

endmodule

@@ src/jpeg_header_marker_parser.sv @@
// ----------------------------------------------------------------------------
// JPEG header marker parser
// Walks the marker segments of a JPEG frame one byte per word and reports
// table writes, frame geometry, restart interval and the header length.
//
// Channel  Dir  Data                                   User
// s_axis   in   data_byte                              frame_start
// m_axis   out  header_length..restart_interval        status
//
// One result word per input word, one per cycle while the output is not stalled.
// The combinational parse step feeds the output register directly.
// Synchronous active-low reset clears parse state, stores and output valid.
// A stalled output holds its word; input is taken whenever the output
// register is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
module jpeg_header_marker_parser
    import jhmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [15:0] header_length, [23:16] marker_code,
                                        // [24] qtable_write, [25] qtable_mirror,
                                        // [26] huff_write, [35:27] table_index,
                                        // [43:36] table_byte, [51:44] width_blocks,
                                        // [59:52] height_blocks,
                                        // [75:60] restart_interval, [79:76] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic         accept;
    t_jhmp_result step_result;
    t_jhmp_result r_out;
    logic         r_out_valid;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    jhmp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {4'd0,
                            r_out.restart_interval,
                            r_out.height_blocks,
                            r_out.width_blocks,
                            r_out.table_byte,
                            r_out.table_index,
                            r_out.huff_write,
                            r_out.qtable_mirror,
                            r_out.qtable_write,
                            r_out.marker_code,
                            r_out.header_length};

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// JPEG header marker parser testbench
// Streams JPEG frame bytes into the parser: a few hand-built frames, then
// mostly well-formed random marker sequences with some noise and broken
// segments. A byte-level predictor computes each result word, which is
// checked against the output stream under varying idle and stall patterns,
// including a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import jhmp_pkg::*;

    typedef enum logic [2:0] {
        SEEK_FF, READ_CODE, LEN_HIGH, LEN_LOW, SEG_BODY, PARSE_DONE
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       fs;
    } t_frame_byte;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] hdr_len;
        logic [7:0]  code;
        logic        qw;
        logic        qm;
        logic        hw;
        logic [8:0]  idx;
        logic [7:0]  tbyte;
        logic [7:0]  wblk;
        logic [7:0]  hblk;
        logic [15:0] rint;
    } t_parse_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;           // [15:0] header_length .. [75:60] restart_interval
    logic [1:0]  m_axis_tuser;           // [1:0] status

    jpeg_header_marker_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_frame_byte  pending_bytes[$];
    t_parse_word  expected_words[$];
    logic         fs_next = 1'b0;
    logic         in_taken = 1'b0;
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_req = 0;
    int           hold_ack = 0;
    int           hold_left = 0;
    int           n_bad = 0;

    // parser state mirror
    t_parse_phase ph = SEEK_FF;
    logic [15:0]  pos = '0;
    logic [7:0]   seg_code = '0;
    logic [15:0]  seg_len = '0;
    logic [15:0]  seg_off = '0;
    logic [7:0]   hi_byte = '0;
    logic [7:0]   w_blk = '0;
    logic [7:0]   h_blk = '0;
    logic [15:0]  rst_int = '0;

    function automatic logic known_code(input logic [7:0] c);
        return c == MK_SOI || c == MK_DRI || c == MK_DQT || c == MK_DHT ||
               c == MK_SOF0 || c == MK_APP0 || c == MK_SOS || c == MK_APP15;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic fs, output t_parse_word w);
        int s;
        logic [15:0] v;
        w = '0;
        if (fs) begin
            ph = SEEK_FF;
            pos = '0;
            seg_code = '0;
            seg_len = '0;
            seg_off = '0;
            hi_byte = '0;
        end
        if (ph != SEEK_FF && ph != PARSE_DONE && pos != 16'hFFFF)
            pos = pos + 16'd1;
        unique case (ph)
            SEEK_FF: begin
                if (b == MK_PREFIX) begin
                    if (pos != 16'hFFFF)
                        pos = pos + 16'd1;
                    ph = READ_CODE;
                end else begin
                    w.status = ST_HEADER_END;
                    w.hdr_len = pos;
                    ph = PARSE_DONE;
                end
            end
            READ_CODE: begin
                seg_code = b;
                if (b == MK_SOI) begin
                    ph = SEEK_FF;
                end else if (known_code(b)) begin
                    ph = LEN_HIGH;
                end else begin
                    w.status = ST_ERROR;
                    ph = PARSE_DONE;
                end
            end
            LEN_HIGH: begin
                hi_byte = b;
                if (seg_code == MK_DHT) begin
                    w.hw = 1'b1;
                    w.idx = 9'd0;
                    w.tbyte = b;
                end
                ph = LEN_LOW;
            end
            LEN_LOW: begin
                seg_len = {hi_byte, b};
                if (seg_len < 16'd2) begin
                    w.status = ST_ERROR;
                    ph = PARSE_DONE;
                end else begin
                    if (seg_code == MK_DHT && HUFF_COPY_BYTES > 1) begin
                        w.hw = 1'b1;
                        w.idx = 9'd1;
                        w.tbyte = b;
                    end
                    seg_off = 16'd2;
                    ph = (seg_len == 16'd2) ? SEEK_FF : SEG_BODY;
                end
            end
            SEG_BODY: begin
                s = int'(seg_off);
                if (seg_code == MK_DQT) begin
                    if (s >= 3 && s < QTABLE_BYTES + 3) begin
                        w.qw = 1'b1;
                        w.idx = 9'(s - 3);
                        w.tbyte = b;
                        w.qm = (seg_len < 2 * QTABLE_BYTES);
                    end else if (seg_len >= 2 * QTABLE_BYTES && s >= QTABLE_BYTES + 4 &&
                                 s < 2 * QTABLE_BYTES + 4) begin
                        w.qw = 1'b1;
                        w.idx = 9'(s - 4);
                        w.tbyte = b;
                    end
                end else if (seg_code == MK_DHT) begin
                    if (s < HUFF_COPY_BYTES) begin
                        w.hw = 1'b1;
                        w.idx = 9'(s);
                        w.tbyte = b;
                    end
                end else if (seg_code == MK_SOF0) begin
                    if (s == 3 || s == 5) begin
                        hi_byte = b;
                    end else if (s == 4 || s == 6) begin
                        v = {hi_byte, b};
                        if (s == 4)
                            h_blk = v[10:3];
                        else
                            w_blk = v[10:3];
                    end
                end else if (seg_code == MK_DRI) begin
                    if (s == 2)
                        hi_byte = b;
                    else if (s == 3)
                        rst_int = {hi_byte, b};
                end
                seg_off = 16'(s + 1);
                if (s + 1 >= seg_len)
                    ph = SEEK_FF;
            end
            default: begin
                w.status = ST_PAST;
                ph = PARSE_DONE;
            end
        endcase
        w.code = seg_code;
        w.wblk = w_blk;
        w.hblk = h_blk;
        w.rint = rst_int;
    endtask

    // ---- stimulus building ----
    task automatic put(input logic [7:0] b);
        t_frame_byte x;
        x.data = b;
        x.fs = fs_next;
        pending_bytes.push_back(x);
        fs_next = 1'b0;
    endtask

    task automatic put_segment(input logic [7:0] code, input int len);
        put(MK_PREFIX);
        put(code);
        put(len[15:8]);
        put(len[7:0]);
        repeat (len - 2) put(8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] unknown_code();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (known_code(c))
            c = 8'($urandom_range(255));
        return c;
    endfunction

    task automatic put_random_frame();
        int nseg;
        int pick;
        int len;
        logic [7:0] code;
        fs_next = 1'b1;
        if ($urandom_range(9) != 0) begin
            put(MK_PREFIX);
            put(MK_SOI);
        end
        nseg = $urandom_range(1, 5);
        repeat (nseg) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                code = MK_DQT;
                if ($urandom_range(9) == 0)
                    len = $urandom_range(1) ? 128 : 132;
                else
                    len = $urandom_range(2, 70);
            end else if (pick < 35) begin
                code = MK_DHT;
                len = ($urandom_range(39) == 0) ? $urandom_range(418, 422)
                                                : $urandom_range(2, 24);
            end else if (pick < 55) begin
                code = MK_SOF0;
                len = $urandom_range(1) ? 17 : $urandom_range(2, 19);
            end else if (pick < 70) begin
                code = MK_DRI;
                len = $urandom_range(1) ? 4 : $urandom_range(2, 6);
            end else begin
                pick = $urandom_range(2);
                code = (pick == 0) ? MK_APP0 : (pick == 1) ? MK_SOS : MK_APP15;
                len = $urandom_range(2, 12);
            end
            put_segment(code, len);
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
            put(8'($urandom_range(254)));
            repeat ($urandom_range(6)) put(8'($urandom_range(255)));
        end else if (pick < 88) begin
            put(MK_PREFIX);
            put(unknown_code());
            put(8'($urandom_range(255)));
        end else if (pick < 94) begin
            put(MK_PREFIX);
            put(MK_APP0);
            put(8'h00);
            put(8'($urandom_range(1)));
        end else begin
            // cut off mid-segment; the next frame start restarts the parse
            put(MK_PREFIX);
            put(MK_DQT);
            put(8'h00);
            put(8'h43);
            repeat ($urandom_range(5)) put(8'($urandom_range(255)));
        end
    endtask

    task automatic put_noise();
        repeat ($urandom_range(1, 8)) begin
            fs_next = ($urandom_range(7) == 0);
            put(8'($urandom_range(255)));
        end
    endtask

    // ---- driver ----
    always @(negedge i_clk) begin : drive_p
        t_frame_byte nxt;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            in_taken = 1'b0;
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                nxt = pending_bytes.pop_front();
                s_axis_tdata <= nxt.data;
                s_axis_tuser <= nxt.fs;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---- receiver ----
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin : mon_p
        t_parse_word want;
        t_parse_word got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tuser, want);
                expected_words.push_back(want);
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status  = m_axis_tuser;
                got.hdr_len = m_axis_tdata[15:0];
                got.code    = m_axis_tdata[23:16];
                got.qw      = m_axis_tdata[24];
                got.qm      = m_axis_tdata[25];
                got.hw      = m_axis_tdata[26];
                got.idx     = m_axis_tdata[35:27];
                got.tbyte   = m_axis_tdata[43:36];
                got.wblk    = m_axis_tdata[51:44];
                got.hblk    = m_axis_tdata[59:52];
                got.rint    = m_axis_tdata[75:60];
                if (expected_words.size() == 0) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("unexpected word at %0t: %h status %0d",
                                 $realtime, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        n_bad = n_bad + 1;
                        if (n_bad <= 10) begin
                            $display("mismatch at %0t", $realtime);
                            $write("  exp st=%0d len=%0d code=%h q=%b%b h=%b",
                                   want.status, want.hdr_len, want.code, want.qw,
                                   want.qm, want.hw);
                            $display(" idx=%0d b=%h w=%0d h=%0d ri=%h",
                                     want.idx, want.tbyte, want.wblk, want.hblk,
                                     want.rint);
                            $write("  got st=%0d len=%0d code=%h q=%b%b h=%b",
                                   got.status, got.hdr_len, got.code, got.qw,
                                   got.qm, got.hw);
                            $display(" idx=%0d b=%h w=%0d h=%0d ri=%h",
                                     got.idx, got.tbyte, got.wblk, got.hblk,
                                     got.rint);
                        end
                    end
                end
            end
        end
    end

    // ---- sequence ----
    initial begin
        int phase;
        int base;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (phase = 0; phase < 4; phase++) begin
            send_gap_pct   = (phase == 1) ? 52 : (phase == 3) ? 16 : 0;
            recv_stall_pct = (phase == 2) ? 52 : (phase == 3) ? 16 : 0;
            if (phase == 0) begin
                // SOI, DRI, header end, then a byte past the end
                fs_next = 1'b1;
                put(MK_PREFIX); put(MK_SOI); put(MK_PREFIX); put(MK_DRI);
                put(8'h00); put(8'h04); put(8'hFF); put(8'h00);
                put(8'h00); put(8'hAB);
                // unknown code
                fs_next = 1'b1;
                put(MK_PREFIX); put(8'h01); put(8'h55);
                // length below two
                fs_next = 1'b1;
                put(MK_PREFIX); put(MK_APP0); put(8'h00); put(8'h01);
                // header of zero length
                fs_next = 1'b1;
                put(8'h00);
                // empty DHT segment
                fs_next = 1'b1;
                put(MK_PREFIX); put(MK_DHT); put(8'h00); put(8'h02); put(8'h7F);
                // Huffman copy limit and full 128-entry quant table
                fs_next = 1'b1;
                put_segment(MK_DHT, 425);
                put_segment(MK_DQT, 132);
                put_segment(MK_SOF0, 17);
                put(8'h00);
                hold_req = hold_req + 1;
            end
            base = pending_bytes.size();
            while (pending_bytes.size() - base < 125) begin
                if ($urandom_range(7) == 0)
                    put_noise();
                else
                    put_random_frame();
            end
            while (pending_bytes.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
                @(negedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (n_bad == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule
